@@ sv/hmtri_pkg.sv @@
// Shared constants, codes and helpers for the heightmap triangle height query.
// No dependencies; the interfaces and the top module import this package, hmtri_ram does not.
package hmtri_pkg;

    localparam int unsigned GRID_SIDE_MAX = 256;
    localparam int unsigned SIDE_W        = $clog2(GRID_SIDE_MAX) + 1;
    localparam int unsigned STORE_DEPTH   = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int unsigned ADDR_W        = 16;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned POS_W         = 16;
    localparam int unsigned FRAC_W        = 8;
    localparam int unsigned CELL_W        = POS_W - FRAC_W;
    localparam int unsigned HEIGHT_W      = 13;
    localparam int unsigned HEIGHT_MAX    = 6528;
    localparam int unsigned BANKS         = 4;

    // M / 10 == (M * 0xCCCD) >> 19 for every 16-bit M
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned RECIP_W     = 16;
    localparam int unsigned RECIP_10    = 52429;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic CFG_GRID_WIDTH = 1'b0;
    localparam logic CFG_GRID_DEPTH = 1'b1;

    // Corner bank order: b0=(cx,cz+1), b1=(cx+1,cz+1), b2=(cx+1,cz), b3=(cx,cz)
    localparam int unsigned BANK_B0 = 0;
    localparam int unsigned BANK_B1 = 1;
    localparam int unsigned BANK_B2 = 2;
    localparam int unsigned BANK_B3 = 3;

    typedef logic [SIDE_W-1:0] t_side;

    function automatic t_side sat_side(input t_side v);
        if (v > t_side'(GRID_SIDE_MAX)) begin
            return t_side'(GRID_SIDE_MAX);
        end
        return v;
    endfunction

endpackage

@@ sv/hmtri_item_if.sv @@
// Input channel of the heightmap query: valid/ready plus the item fields.
// Depends on hmtri_pkg for field widths.
interface hmtri_item_if import hmtri_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [ADDR_W-1:0]   vertex_index;
    logic [BYTE_W-1:0]   raw_height;
    logic [POS_W-1:0]    query_x;
    logic [POS_W-1:0]    query_z;

    modport source (output valid, action, vertex_index, raw_height, query_x, query_z,
                    input ready);
    modport sink   (input valid, action, vertex_index, raw_height, query_x, query_z,
                    output ready);
endinterface

@@ sv/hmtri_result_if.sv @@
// Result channel of the heightmap query: valid/ready plus height and range flag.
// Depends on hmtri_pkg for field widths.
interface hmtri_result_if import hmtri_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;
    logic                out_of_range;

    modport source (output valid, height, out_of_range, input ready);
    modport sink   (input valid, height, out_of_range, output ready);
endinterface

@@ sv/hmtri_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module hmtri_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/heightmap_triangle_height_query.sv @@
// 5 register stages; result valid and data come from the stage-5 registers. Throughput is one
// item per cycle while the result channel is ready; a waiting result holds the pipeline.
// Four replicated height RAMs each give one corner read per cycle while stage 2 advances, so queries stream.
// Height writes take the RAM stage and then drop out without a result.
// Reset (synchronous, active low) clears all stage valid bits and sets both grid
// sizes to 256. Height store contents stay undefined until written; no clearing pass.
module heightmap_triangle_height_query import hmtri_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [SIDE_W-1:0] i_cfg_data,
    hmtri_item_if.sink        i_item,
    hmtri_result_if.source    o_result
);

    // ------------------------------------------------------------------
    // Configuration: saturate grid sizes to the store side.
    // ------------------------------------------------------------------
    t_side r_grid_w;
    t_side r_grid_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= t_side'(GRID_SIDE_MAX);
            r_grid_d <= t_side'(GRID_SIDE_MAX);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_WIDTH: r_grid_w <= sat_side(i_cfg_data);
                CFG_GRID_DEPTH: r_grid_d <= sat_side(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage advances when its successor is empty or moving,
    // so bubbles fill while a result waits at the output.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5 = !r_v5 || o_result.ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_item.ready = w_en1;

    // ------------------------------------------------------------------
    // Stage 1: split position, range check, row-major cell base.
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] w_cx, w_cz;
    logic              n_oor1;
    logic [ADDR_W:0]   n_base1;

    assign w_cx = i_item.query_x[POS_W-1:FRAC_W];
    assign w_cz = i_item.query_z[POS_W-1:FRAC_W];
    assign n_oor1 = (t_side'(w_cx) + t_side'(1) >= r_grid_w) ||
                    (t_side'(w_cz) + t_side'(1) >= r_grid_d);
    assign n_base1 = (ADDR_W+1)'(w_cz) * (ADDR_W+1)'(r_grid_w) + (ADDR_W+1)'(w_cx);

    logic              r_act1;
    logic [ADDR_W-1:0] r_vidx1;
    logic [BYTE_W-1:0] r_raw1;
    logic              r_oor1;
    logic [FRAC_W-1:0] r_fx1, r_fz1;
    logic [ADDR_W:0]   r_base1;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_act1  <= i_item.action;
            r_vidx1 <= i_item.vertex_index;
            r_raw1  <= i_item.raw_height;
            r_oor1  <= n_oor1;
            r_fx1   <= i_item.query_x[FRAC_W-1:0];
            r_fz1   <= i_item.query_z[FRAC_W-1:0];
            r_base1 <= n_base1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: corner reads from four RAM copies; writes update every copy.
    // ------------------------------------------------------------------
    logic [ADDR_W:0]   w_row_up;
    logic [ADDR_W-1:0] w_raddr [BANKS];
    logic [BYTE_W-1:0] w_rdata [BANKS];
    logic              w_wr;

    assign w_row_up = r_base1 + (ADDR_W+1)'(r_grid_w);
    assign w_raddr[BANK_B3] = r_base1[ADDR_W-1:0];
    assign w_raddr[BANK_B2] = ADDR_W'(r_base1 + (ADDR_W+1)'(1));
    assign w_raddr[BANK_B0] = w_row_up[ADDR_W-1:0];
    assign w_raddr[BANK_B1] = ADDR_W'(w_row_up + (ADDR_W+1)'(1));

    // commit a height write as the item leaves stage 1
    assign w_wr = r_v1 && (r_act1 == ACT_WRITE) && w_en2;

    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        hmtri_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr),
            .i_waddr (r_vidx1),
            .i_wdata (r_raw1),
            .i_re    (w_en2),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_rdata[g])
        );
    end

    logic              r_oor2;
    logic [FRAC_W-1:0] r_fx2, r_fz2;
    logic              r_up2;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_oor2 <= r_oor1;
            r_fx2  <= r_fx1;
            r_fz2  <= r_fz1;
            // upper triangle when fx + fz > 1.0
            r_up2  <= ({1'b0, r_fx1} + {1'b0, r_fz1}) > (FRAC_W+1)'(1 << FRAC_W);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pick the triangle and form both slope products.
    //   M = 256*base + dx*gx + dz*gz, height = floor(M / 10)
    // ------------------------------------------------------------------
    logic [FRAC_W:0]          w_gx, w_gz;
    logic signed [BYTE_W:0]   w_dx, w_dz;
    logic [BYTE_W-1:0]        w_base;
    logic signed [2*FRAC_W+2:0] n_px3, n_pz3;

    always_comb begin
        if (r_up2) begin
            w_gx   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, r_fx2};
            w_gz   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, r_fz2};
            w_base = w_rdata[BANK_B1];
            w_dx   = $signed({1'b0, w_rdata[BANK_B0]}) - $signed({1'b0, w_rdata[BANK_B1]});
            w_dz   = $signed({1'b0, w_rdata[BANK_B2]}) - $signed({1'b0, w_rdata[BANK_B1]});
        end else begin
            w_gx   = {1'b0, r_fx2};
            w_gz   = {1'b0, r_fz2};
            w_base = w_rdata[BANK_B3];
            w_dx   = $signed({1'b0, w_rdata[BANK_B2]}) - $signed({1'b0, w_rdata[BANK_B3]});
            w_dz   = $signed({1'b0, w_rdata[BANK_B0]}) - $signed({1'b0, w_rdata[BANK_B3]});
        end
        n_px3 = (2*FRAC_W+3)'(w_dx) * (2*FRAC_W+3)'($signed({1'b0, w_gx}));
        n_pz3 = (2*FRAC_W+3)'(w_dz) * (2*FRAC_W+3)'($signed({1'b0, w_gz}));
    end

    logic                       r_oor3;
    logic [BYTE_W-1:0]          r_base3;
    logic signed [2*FRAC_W+2:0] r_px3, r_pz3;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_oor3  <= r_oor2;
            r_base3 <= w_base;
            r_px3   <= n_px3;
            r_pz3   <= n_pz3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum the plane terms, floor negatives at zero.
    // ------------------------------------------------------------------
    logic signed [2*FRAC_W+3:0] w_sum;
    logic [SUM_W-1:0]           n_m4;

    assign w_sum = $signed({4'b0, r_base3, {FRAC_W{1'b0}}})
                 + (2*FRAC_W+4)'(r_px3) + (2*FRAC_W+4)'(r_pz3);
    assign n_m4  = (w_sum < 0) ? '0 : w_sum[SUM_W-1:0];

    logic             r_oor4;
    logic [SUM_W-1:0] r_m4;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_oor4 <= r_oor3;
            r_m4   <= n_m4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: divide by ten through the reciprocal, clamp, zero when out of grid.
    // ------------------------------------------------------------------
    logic [SUM_W+RECIP_W-1:0] w_prod;
    logic [HEIGHT_W-1:0]      w_quot;
    logic [HEIGHT_W-1:0]      n_h5;

    assign w_prod = (SUM_W+RECIP_W)'(r_m4) * (SUM_W+RECIP_W)'(RECIP_10);
    assign w_quot = w_prod[RECIP_SHIFT +: HEIGHT_W];

    always_comb begin
        if (r_oor4) begin
            n_h5 = '0;
        end else if (w_quot > HEIGHT_W'(HEIGHT_MAX)) begin
            n_h5 = HEIGHT_W'(HEIGHT_MAX);
        end else begin
            n_h5 = w_quot;
        end
    end

    logic [HEIGHT_W-1:0] r_h5;
    logic                r_oor5;

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_h5   <= n_h5;
            r_oor5 <= r_oor4;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits: writes drop out after the RAM stage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_item.valid;
            if (w_en2) r_v2 <= r_v1 && (r_act1 == ACT_QUERY);
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    assign o_result.valid        = r_v5;
    assign o_result.height       = r_h5;
    assign o_result.out_of_range = r_oor5;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && r_oor5 |-> r_h5 == '0)
        else $error("out-of-grid result carries nonzero height");

    a_height_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> r_h5 <= HEIGHT_W'(HEIGHT_MAX))
        else $error("result height above maximum");

    a_write_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && (r_act1 == ACT_WRITE) && w_en2 |=> !r_v2)
        else $error("height write produced a pipeline item");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !r_oor4 |-> r_m4 <= SUM_W'(255 << FRAC_W))
        else $error("plane sum outside corner height range");

endmodule
